[rtl/core/y2r_pkg.sv]
// y2r_pkg: beat types and BT.601 coefficients for the 4:2:2 to RGB565 converter
// no dependencies; imported by ycbcr422_to_rgb565_converter
package y2r_pkg;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       line_end_in;
    logic       frame_end_in;
  } y2r_in_t;

  typedef struct packed {
    logic [15:0] pixel_first;
    logic [15:0] pixel_second;
    logic        line_end_out;
    logic        frame_end_out;
  } y2r_out_t;

  // signed width that holds every product and every channel sum
  localparam int SumW = 20;

  localparam logic signed [SumW-1:0] CoefY    = 20'sd298;
  localparam logic signed [SumW-1:0] CoefRCr  = 20'sd409;
  localparam logic signed [SumW-1:0] CoefGCb  = 20'sd100;
  localparam logic signed [SumW-1:0] CoefGCr  = 20'sd208;
  localparam logic signed [SumW-1:0] CoefBCb  = 20'sd516;
  localparam logic signed [SumW-1:0] RoundAdd = 20'sd128;
  localparam logic [8:0]             LumaOff  = 9'd16;
  localparam logic [7:0]             ChromaOff = 8'd128;
  localparam logic [7:0]             ChanMax  = 8'd255;

  // floor shift by 8 and saturate to 0..255
  function automatic logic [7:0] clamp_chan(input logic signed [SumW-1:0] sum);
    logic signed [SumW-9:0] v;
    begin
      v = sum[SumW-1:8];
      if (v < 0) begin
        clamp_chan = 8'd0;
      end else if (v > $signed({4'd0, ChanMax})) begin
        clamp_chan = ChanMax;
      end else begin
        clamp_chan = v[7:0];
      end
    end
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    pack565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

[rtl/core/ycbcr422_to_rgb565_converter.sv]
// an accepted input beat passes through the product, sum and output registers in turn
// throughput: one 4:2:2 pair per cycle while out_ready_i is high; three register stages (products, sums,
// clamp and pack into the output register), each moving when the one after it is free
// reset: rst_ni clears the stage valid bits and gray_q; data registers keep garbage
// package y2r_pkg supplies the beat types, coefficients and clamp/pack helpers
module ycbcr422_to_rgb565_converter
  import y2r_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  y2r_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output y2r_out_t out_data_o
);

  logic gray_q;

  // stage 1: products
  logic                   s1_valid_q;
  logic                   s1_gray_q;
  logic [7:0]             s1_y0_q, s1_y1_q;
  logic                   s1_le_q, s1_fe_q;
  logic signed [SumW-1:0] s1_py0_q, s1_py1_q, s1_rcr_q, s1_gcb_q, s1_gcr_q, s1_bcb_q;

  // stage 2: channel sums
  logic                   s2_valid_q;
  logic                   s2_gray_q;
  logic [7:0]             s2_y0_q, s2_y1_q;
  logic                   s2_le_q, s2_fe_q;
  logic signed [SumW-1:0] s2_r0_q, s2_g0_q, s2_b0_q, s2_r1_q, s2_g1_q, s2_b1_q;

  logic     out_valid_q;
  y2r_out_t out_data_q;

  logic en1, en2, en3;

  assign en3        = !out_valid_q || out_ready_i;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;

  logic signed [SumW-1:0] c0, c1, d, e;

  always_comb begin
    c0 = SumW'($signed({1'b0, in_data_i.luma_first} - LumaOff));
    c1 = SumW'($signed({1'b0, in_data_i.luma_second} - LumaOff));
    d  = SumW'($signed(in_data_i.chroma_blue - ChromaOff));
    e  = SumW'($signed(in_data_i.chroma_red - ChromaOff));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gray_q <= cfg_wdata_i;
      end
      if (en1) begin
        s1_valid_q <= in_valid_i;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (en3) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_gray_q <= gray_q;
      s1_y0_q   <= in_data_i.luma_first;
      s1_y1_q   <= in_data_i.luma_second;
      s1_le_q   <= in_data_i.line_end_in;
      s1_fe_q   <= in_data_i.frame_end_in;
      s1_py0_q  <= c0 * CoefY;
      s1_py1_q  <= c1 * CoefY;
      s1_rcr_q  <= e * CoefRCr;
      s1_gcb_q  <= d * CoefGCb;
      s1_gcr_q  <= e * CoefGCr;
      s1_bcb_q  <= d * CoefBCb;
    end
    if (en2 && s1_valid_q) begin
      s2_gray_q <= s1_gray_q;
      s2_y0_q   <= s1_y0_q;
      s2_y1_q   <= s1_y1_q;
      s2_le_q   <= s1_le_q;
      s2_fe_q   <= s1_fe_q;
      s2_r0_q   <= s1_py0_q + s1_rcr_q + RoundAdd;
      s2_g0_q   <= s1_py0_q - s1_gcb_q - s1_gcr_q + RoundAdd;
      s2_b0_q   <= s1_py0_q + s1_bcb_q + RoundAdd;
      s2_r1_q   <= s1_py1_q + s1_rcr_q + RoundAdd;
      s2_g1_q   <= s1_py1_q - s1_gcb_q - s1_gcr_q + RoundAdd;
      s2_b1_q   <= s1_py1_q + s1_bcb_q + RoundAdd;
    end
    if (en3 && s2_valid_q) begin
      if (s2_gray_q) begin
        out_data_q.pixel_first  <= pack565(s2_y0_q, s2_y0_q, s2_y0_q);
        out_data_q.pixel_second <= pack565(s2_y1_q, s2_y1_q, s2_y1_q);
      end else begin
        out_data_q.pixel_first  <= pack565(clamp_chan(s2_r0_q), clamp_chan(s2_g0_q),
                                           clamp_chan(s2_b0_q));
        out_data_q.pixel_second <= pack565(clamp_chan(s2_r1_q), clamp_chan(s2_g1_q),
                                           clamp_chan(s2_b1_q));
      end
      out_data_q.line_end_out  <= s2_le_q;
      out_data_q.frame_end_out <= s2_fe_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/core/y2r_checker.sv]
// y2r_checker: port-level assertions for ycbcr422_to_rgb565_converter
// depends on y2r_pkg for the beat types; bound to the top level below
module y2r_checker
  import y2r_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input y2r_out_t out_data_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // an empty output register means the pipeline has room
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready with output register empty");

  // with the sink ready, an accepted beat passes the product and sum stages into the output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("accepted beat did not reach the output");

  // nothing leaves straight after reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind ycbcr422_to_rgb565_converter y2r_checker u_y2r_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[sim/ycbcr422_to_rgb565_converter_tb.sv]
// testbench for ycbcr422_to_rgb565_converter: 4:2:2 pairs in, RGB565 pairs out, gray mode
// depends on y2r_pkg and the converter rtl; self-checking against its own BT.601 predictor
`timescale 1ns / 1ps

module ycbcr422_to_rgb565_converter_tb;
  import y2r_pkg::*;

  localparam int HalfPeriod  = 2;
  localparam int ResetCycles = 10;
  localparam int TailCycles  = 8;
  localparam int CycleLimit  = 200000;
  localparam int MaxGap      = 15;
  localparam int ReportLimit = 10;
  localparam int PhasePairs  = 150;
  localparam int ChunkPairs  = 25;
  localparam logic ModeColour = 1'b0;
  localparam logic ModeGray   = 1'b1;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  logic     cfg_wdata_i;
  logic     in_valid_i;
  logic     in_ready_o;
  y2r_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  y2r_out_t out_data_o;

  logic     gray_model;
  logic     src_idle;
  logic     snk_idle;
  y2r_out_t expected_pairs[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;

  ycbcr422_to_rgb565_converter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #(HalfPeriod);
    clk_i = 1'b1;
    #(HalfPeriod);
  end

  // floor divide by 256, then saturate to one byte
  function automatic logic [7:0] saturate_chan(input int acc);
    int v;
    v = acc >>> 8;
    if (v < 0) begin
      return 8'd0;
    end else if (v > 255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  function automatic logic [15:0] to_rgb565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] bt601_pixel(input logic [7:0] y, input logic [7:0] cb,
                                              input logic [7:0] cr);
    int c;
    int d;
    int e;
    c = int'(y) - 16;
    d = int'(cb) - 128;
    e = int'(cr) - 128;
    return to_rgb565(saturate_chan(298 * c + 409 * e + 128),
                     saturate_chan(298 * c - 100 * d - 208 * e + 128),
                     saturate_chan(298 * c + 516 * d + 128));
  endfunction

  function automatic y2r_out_t convert_pair(input y2r_in_t beat, input logic gray);
    y2r_out_t res;
    if (gray == ModeGray) begin
      res.pixel_first  = to_rgb565(beat.luma_first, beat.luma_first, beat.luma_first);
      res.pixel_second = to_rgb565(beat.luma_second, beat.luma_second, beat.luma_second);
    end else begin
      res.pixel_first  = bt601_pixel(beat.luma_first, beat.chroma_blue, beat.chroma_red);
      res.pixel_second = bt601_pixel(beat.luma_second, beat.chroma_blue, beat.chroma_red);
    end
    res.line_end_out  = beat.line_end_in;
    res.frame_end_out = beat.frame_end_in;
    return res;
  endfunction

  // mostly uniform, now and then hugging the limited-range edges
  function automatic logic [7:0] random_sample();
    if ($urandom_range(0, 7) == 0) begin
      return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 16))
                                         : 8'($urandom_range(235, 255));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic y2r_in_t random_pair();
    y2r_in_t beat;
    beat.luma_first   = random_sample();
    beat.chroma_blue  = random_sample();
    beat.luma_second  = random_sample();
    beat.chroma_red   = random_sample();
    beat.line_end_in  = ($urandom_range(0, 7) == 0);
    beat.frame_end_in = beat.line_end_in ? ($urandom_range(0, 3) == 0)
                                         : ($urandom_range(0, 31) == 0);
    return beat;
  endfunction

  task automatic note_mismatch(input string field, input logic [33:0] want,
                               input logic [33:0] got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("mismatch on %s at cycle %0d: expected %h, got %h",
               field, cycle_count, want, got);
    end
  endtask

  task automatic send_pair(input y2r_in_t beat);
    int gap;
    gap = src_idle ? $urandom_range(0, MaxGap) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    expected_pairs.push_back(convert_pair(beat, gray_model));
  endtask

  // hold off the sender until the pipeline has emptied
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    gray_model = mode;
  endtask

  task automatic test_reset_default();
    send_pair(y2r_in_t'({8'd128, 8'd64, 8'd200, 8'd192, 1'b0, 1'b0}));
    send_pair(y2r_in_t'({8'd60, 8'd200, 8'd30, 8'd40, 1'b1, 1'b1}));
  endtask

  task automatic test_colour_extremes();
    logic [33:0] cases[11];
    cases = '{
      {8'd0,   8'd0,   8'd255, 8'd0,   1'b0, 1'b0},
      {8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 1'b0},
      {8'd16,  8'd128, 8'd235, 8'd128, 1'b0, 1'b1},
      {8'd255, 8'd0,   8'd0,   8'd255, 1'b1, 1'b1},
      {8'd255, 8'd255, 8'd0,   8'd0,   1'b0, 1'b0},
      {8'd235, 8'd240, 8'd16,  8'd16,  1'b0, 1'b0},
      {8'd128, 8'd16,  8'd128, 8'd240, 1'b1, 1'b0},
      {8'd81,  8'd90,  8'd145, 8'd54,  1'b0, 1'b0},
      {8'd41,  8'd240, 8'd210, 8'd110, 1'b0, 1'b1},
      {8'd255, 8'd128, 8'd0,   8'd128, 1'b0, 1'b0},
      {8'hAA,  8'h55,  8'h55,  8'hAA,  1'b1, 1'b0}
    };
    write_mode(ModeColour);
    foreach (cases[i]) send_pair(y2r_in_t'(cases[i]));
  endtask

  // chroma is random here since gray output must ignore it
  task automatic test_gray_mode();
    logic [15:0] lumas[4];
    y2r_in_t beat;
    lumas = '{{8'd0, 8'd255}, {8'h07, 8'hF8}, {8'hAA, 8'h55}, {8'd16, 8'd235}};
    write_mode(ModeGray);
    foreach (lumas[i]) begin
      beat = random_pair();
      beat.luma_first   = lumas[i][15:8];
      beat.luma_second  = lumas[i][7:0];
      beat.line_end_in  = i[0];
      beat.frame_end_in = i[1];
      send_pair(beat);
    end
  endtask

  task automatic test_random_stream();
    logic modes[6];
    modes = '{ModeColour, ModeGray, ModeColour, ModeColour, ModeGray, ModeColour};
    foreach (modes[p]) begin
      write_mode(modes[p]);
      for (int n = 0; n < PhasePairs; n++) begin
        // some chunks run with no idling on one or both sides
        if (n % ChunkPairs == 0) begin
          src_idle = ($urandom_range(0, 3) != 0);
          snk_idle = ($urandom_range(0, 3) != 0);
        end
        send_pair(random_pair());
      end
    end
  endtask

  always @(posedge clk_i) begin : check_beats
    y2r_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pairs.size() == 0) begin
        note_mismatch("unexpected beat", '0, out_data_o);
      end else begin
        want = expected_pairs.pop_front();
        if (out_data_o.pixel_first !== want.pixel_first)
          note_mismatch("pixel_first", 34'(want.pixel_first),
                        34'(out_data_o.pixel_first));
        if (out_data_o.pixel_second !== want.pixel_second)
          note_mismatch("pixel_second", 34'(want.pixel_second),
                        34'(out_data_o.pixel_second));
        if (out_data_o.line_end_out !== want.line_end_out)
          note_mismatch("line_end_out", 34'(want.line_end_out),
                        34'(out_data_o.line_end_out));
        if (out_data_o.frame_end_out !== want.frame_end_out)
          note_mismatch("frame_end_out", 34'(want.frame_end_out),
                        34'(out_data_o.frame_end_out));
      end
    end
  end

  initial begin : sink
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = snk_idle ? $urandom_range(0, MaxGap) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    gray_model  = ModeColour;
    src_idle    = 1'b1;
    snk_idle    = 1'b1;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_default();
    test_colour_extremes();
    test_gray_mode();
    test_random_stream();
    wait_idle();

    if (mismatch_count == 0 && expected_pairs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
